>>> design/byte_unstuffing_deframer_core_assert.svh
// Assertion macros used by the checker file of the deframer.
`ifndef BYTE_UNSTUFFING_DEFRAMER_CORE_ASSERT_SVH
`define BYTE_UNSTUFFING_DEFRAMER_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define BUD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

// Consequent must hold in the same cycle as the antecedent.
`define BUD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

`endif

>>> design/bud_pkg.sv
// ----------------------------------------------------------------------------
// bud_pkg
// Shared types and constants of the byte unstuffing deframer.
// ----------------------------------------------------------------------------
package bud_pkg;

    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG_CODE = 8'h01;
    localparam logic [7:0] ESC_ESC_CODE  = 8'h02;

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_BAD_ESCAPE     = 2'd1;
    localparam logic [1:0] ST_ESC_BEFORE_END = 2'd2;
    localparam logic [1:0] ST_OVERFLOW       = 2'd3;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    typedef struct packed {
        logic        escape_pending;
        logic [15:0] byte_count;
        logic [1:0]  error_code;
    } t_frame_state;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [15:0] decoded_len;
    } t_result;

endpackage

>>> design/bud_decode.sv
// ----------------------------------------------------------------------------
// bud_decode
// Per-byte decision: next frame state and the optional result item.
// ----------------------------------------------------------------------------
module bud_decode
    import bud_pkg::*;
(
    input  logic [7:0]   i_byte,
    input  logic [15:0]  i_capacity,
    input  t_frame_state i_state,
    output t_frame_state o_state,
    output logic         o_result_valid,
    output t_result      o_result
);

    logic [16:0] w_count_inc;
    logic        w_overflow;
    logic        w_is_data;
    logic        w_is_end;
    logic [7:0]  w_data_byte;
    logic [1:0]  w_err;
    logic [1:0]  w_end_err;

    assign w_count_inc = {1'b0, i_state.byte_count} + 17'd1;
    assign w_overflow  = w_count_inc > {1'b0, i_capacity};

    always_comb begin
        w_is_data   = 1'b0;
        w_is_end    = 1'b0;
        w_data_byte = i_byte;
        w_err       = i_state.error_code;
        o_state     = i_state;
        o_state.escape_pending = 1'b0;
        if (i_state.escape_pending) begin
            case (i_byte)
                FLAG_BYTE: begin
                    w_is_end = 1'b1;
                    if (w_err == ST_OK) w_err = ST_ESC_BEFORE_END;
                end
                ESC_FLAG_CODE: begin
                    w_is_data   = 1'b1;
                    w_data_byte = FLAG_BYTE;
                end
                ESC_ESC_CODE: begin
                    w_is_data   = 1'b1;
                    w_data_byte = ESC_BYTE;
                end
                default: begin
                    if (w_err == ST_OK) w_err = ST_BAD_ESCAPE;
                end
            endcase
        end else begin
            case (i_byte)
                FLAG_BYTE: w_is_end = 1'b1;
                ESC_BYTE:  o_state.escape_pending = 1'b1;
                default:   w_is_data = 1'b1;
            endcase
        end

        // Check capacity on the terminator too; it is emitted regardless.
        w_end_err = (w_err == ST_OK && w_overflow) ? ST_OVERFLOW : w_err;

        o_result_valid        = 1'b0;
        o_result.out_byte     = w_data_byte;
        o_result.frame_end    = 1'b0;
        o_result.frame_status = ST_OK;
        o_result.decoded_len  = w_count_inc[15:0];
        o_state.error_code    = w_err;

        if (w_is_end) begin
            o_result_valid        = 1'b1;
            o_result.out_byte     = FLAG_BYTE;
            o_result.frame_end    = 1'b1;
            o_result.frame_status = w_end_err;
            o_result.decoded_len  = w_count_inc[16] ? 16'hFFFF : w_count_inc[15:0];
            o_state.escape_pending = 1'b0;
            o_state.byte_count     = '0;
            o_state.error_code     = ST_OK;
        end else if (w_is_data && w_err == ST_OK) begin
            if (w_overflow) begin
                o_state.error_code = ST_OVERFLOW;
            end else begin
                o_result_valid     = 1'b1;
                o_state.byte_count = w_count_inc[15:0];
            end
        end
    end

endmodule

>>> design/bud_out_reg.sv
// ----------------------------------------------------------------------------
// bud_out_reg
// Result register toward the master-side stream; holds while stalled.
// ----------------------------------------------------------------------------
module bud_out_reg
    import bud_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or when the current transaction completes this cycle.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load)      n_valid = 1'b1;
        else if (i_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> design/byte_unstuffing_deframer_core.sv
// ----------------------------------------------------------------------------
// byte_unstuffing_deframer_core
// Removes byte stuffing from a link byte stream and marks frame ends.
// ----------------------------------------------------------------------------
// Usage:
//   Slave-side stream takes one stuffed link byte per transaction in
//   tdata[7:0]. 0x7E ends a frame, 0x7D escapes the following byte.
//   Master-side stream gives one result per decoded byte and one per
//   terminator: tdata[7:0] byte, tdata[23:8] running frame length,
//   tlast on the terminator, tuser[1:0] frame status on the terminator.
//   Escape bytes, bad codes, overflow bytes and bytes after an error give no result.
//   Configuration channel writes frame_capacity (16 bits); it is always
//   ready and must be written only while the block is idle.
// Timing:
//   Throughput is one byte per cycle while the receiver keeps up. An
//   accepted input transaction passes the input register, then the
//   decode, then the result register on its way to the output.
//   When the receiver stalls, the result register holds; the input
//   register still drains bytes that make no result, and s_axis_tready
//   falls only once a pending byte needs the occupied result register.
// Reset: synchronous, active low; clears both registers' valid flags and
//   the frame state, and sets frame_capacity to 65535.
// ----------------------------------------------------------------------------
module byte_unstuffing_deframer_core
    import bud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // frame_capacity
    // slave-side stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] in_byte
    // master-side stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [7:0] out_byte, [23:8] decoded_len
    output logic        o_m_axis_tlast,  // frame_end
    output logic [1:0]  o_m_axis_tuser   // [1:0] frame_status
);

    logic [15:0]  r_capacity;
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    t_frame_state r_state;
    t_frame_state n_state;
    logic         w_res_valid;
    t_result      w_result;
    t_result      w_out;
    logic         w_out_free;
    logic         w_consume;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Retire the held byte when it makes no result or the result slot is free.
    assign w_consume       = r_in_valid && (!w_res_valid || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Payload: load on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    bud_decode u_decode (
        .i_byte         (r_in_byte),
        .i_capacity     (r_capacity),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result_valid (w_res_valid),
        .o_result       (w_result)
    );

    // Advance the frame state only when the held byte retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_consume) begin
            r_state <= n_state;
        end
    end

    bud_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_consume && w_res_valid),
        .i_result (w_result),
        .i_ready  (i_m_axis_tready),
        .o_free   (w_out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_result (w_out)
    );

    assign o_m_axis_tdata = {w_out.decoded_len, w_out.out_byte};
    assign o_m_axis_tlast = w_out.frame_end;
    assign o_m_axis_tuser = w_out.frame_status;

endmodule

>>> design/bud_checker.sv
// ----------------------------------------------------------------------------
// bud_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_unstuffing_deframer_core_assert.svh"

module bud_checker
    import bud_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser
);

    // Stalled result holds its payload.
    `BUD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // Terminator result carries the flag byte.
    `BUD_ASSERT_SAME(a_end_flag, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata[7:0] == FLAG_BYTE)

    // Data results always report ok status.
    `BUD_ASSERT_SAME(a_data_ok, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tuser == ST_OK)

    // Every result counts at least itself.
    `BUD_ASSERT_SAME(a_len_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[23:8] != 16'd0)

endmodule

bind byte_unstuffing_deframer_core bud_checker u_bud_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte unstuffing deframer.
// ----------------------------------------------------------------------------
// A queue of stuffed link bytes feeds a clocked stream driver. Each accepted
// input transaction runs through a local predictor of the frame state, and
// any decoded byte or terminator it yields is queued as an expected result.
// A clocked monitor pops one expectation per output transaction and compares
// every field. The run starts with short directed frames: plain data, both
// escape codes, a bad escape code, an escape before the terminator, overflow
// at capacity 1 and 0, and a capacity change inside an open frame. It then
// sends random traffic at several capacities, one phase of it with no idling
// on either side. Elsewhere both sides idle at random. One phase also holds
// off the receiver for a long stretch and pauses the sender until every
// result is in.
// ----------------------------------------------------------------------------
module tb;
    import bud_pkg::*;

    // Longest gap without any transaction in a correct run is the receiver
    // hold-off plus random idle time; allow several times that.
    localparam int STALL_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT    = 50;

    typedef enum int {
        TK_GOOD_FRAME,
        TK_BAD_ESCAPE,
        TK_ESC_AT_END,
        TK_NOISE
    } t_traffic_kind;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;    // [7:0] out_byte, [23:8] decoded_len
    logic        o_m_axis_tlast;    // frame_end
    logic [1:0]  o_m_axis_tuser;    // [1:0] frame_status

    // Predictor state, a private copy of the frame state and the register.
    logic        esc_due        = 1'b0;
    logic [15:0] decoded_count  = '0;
    logic [1:0]  first_error    = ST_OK;
    logic [15:0] frame_capacity = CAPACITY_RESET;

    logic [7:0]  link_bytes_q[$];
    t_result     decoded_q[$];
    t_result     want_result;

    int          tx_idle_pct = 31;
    int          rx_idle_pct = 31;
    logic        tx_hold     = 1'b0;
    logic        rx_hold_req = 1'b0;
    logic        rx_hold_ack = 1'b0;
    int          rx_hold_left = 0;
    int          idle_cycles  = 0;
    int          mismatch_count  = 0;
    int          results_checked = 0;

    byte_unstuffing_deframer_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void note_fault(input logic [1:0] code);
        if (first_error == ST_OK) begin
            first_error = code;
        end
    endfunction

    function automatic logic fits_capacity();
        return ({1'b0, decoded_count} + 17'd1) <= {1'b0, frame_capacity};
    endfunction

    // Advance the frame state by one link byte; queue any result it yields.
    function automatic void deframe_byte(input logic [7:0] link_byte);
        logic [7:0] data;
        logic       have_data;
        logic       is_end;
        t_result    res;
        data      = link_byte;
        have_data = 1'b0;
        is_end    = 1'b0;
        if (esc_due) begin
            esc_due = 1'b0;
            if (link_byte == FLAG_BYTE) begin
                note_fault(ST_ESC_BEFORE_END);
                is_end = 1'b1;
            end else if (link_byte == ESC_FLAG_CODE) begin
                data      = FLAG_BYTE;
                have_data = 1'b1;
            end else if (link_byte == ESC_ESC_CODE) begin
                data      = ESC_BYTE;
                have_data = 1'b1;
            end else begin
                note_fault(ST_BAD_ESCAPE);
            end
        end else if (link_byte == FLAG_BYTE) begin
            is_end = 1'b1;
        end else if (link_byte == ESC_BYTE) begin
            esc_due = 1'b1;
        end else begin
            have_data = 1'b1;
        end

        // Drop data once the frame has an error; count stops with it.
        if (have_data && first_error == ST_OK) begin
            if (!fits_capacity()) begin
                note_fault(ST_OVERFLOW);
            end else begin
                decoded_count      = decoded_count + 16'd1;
                res.out_byte       = data;
                res.frame_end      = 1'b0;
                res.frame_status   = ST_OK;
                res.decoded_len    = decoded_count;
                decoded_q.push_back(res);
            end
        end

        // The terminator is always emitted, length saturated at 16 bits.
        if (is_end) begin
            if (first_error == ST_OK && !fits_capacity()) begin
                note_fault(ST_OVERFLOW);
            end
            res.out_byte     = FLAG_BYTE;
            res.frame_end    = 1'b1;
            res.frame_status = first_error;
            res.decoded_len  = (decoded_count == 16'hFFFF) ? 16'hFFFF
                                                           : decoded_count + 16'd1;
            decoded_q.push_back(res);
            esc_due       = 1'b0;
            decoded_count = '0;
            first_error   = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Bias toward the two bytes that need stuffing.
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Stuff one decoded byte onto the link.
    function automatic void queue_data_byte(input logic [7:0] data);
        if (data == FLAG_BYTE) begin
            link_bytes_q.push_back(ESC_BYTE);
            link_bytes_q.push_back(ESC_FLAG_CODE);
        end else if (data == ESC_BYTE) begin
            link_bytes_q.push_back(ESC_BYTE);
            link_bytes_q.push_back(ESC_ESC_CODE);
        end else begin
            link_bytes_q.push_back(data);
        end
    endfunction

    function automatic logic [7:0] pick_bad_code();
        logic [7:0] code;
        do begin
            code = 8'($urandom_range(0, 255));
        end while (code == ESC_FLAG_CODE || code == ESC_ESC_CODE || code == FLAG_BYTE);
        return code;
    endfunction

    // Mostly well-formed frames with random content; the rest broken frames
    // and raw noise.
    function automatic void queue_random_traffic(input int n_bytes, input int max_len);
        int            start;
        int            len;
        int            roll;
        t_traffic_kind kind;
        start = link_bytes_q.size();
        while (link_bytes_q.size() - start < n_bytes) begin
            roll = $urandom_range(0, 9);
            len  = $urandom_range(0, max_len);
            kind = (roll < 7) ? TK_GOOD_FRAME :
                   (roll == 7) ? TK_BAD_ESCAPE :
                   (roll == 8) ? TK_ESC_AT_END : TK_NOISE;
            case (kind)
                TK_GOOD_FRAME: begin
                    repeat (len) queue_data_byte(pick_data());
                    link_bytes_q.push_back(FLAG_BYTE);
                end
                TK_BAD_ESCAPE: begin
                    repeat (len / 2) queue_data_byte(pick_data());
                    link_bytes_q.push_back(ESC_BYTE);
                    link_bytes_q.push_back(pick_bad_code());
                    repeat (len - len / 2) queue_data_byte(pick_data());
                    link_bytes_q.push_back(FLAG_BYTE);
                end
                TK_ESC_AT_END: begin
                    repeat (len) queue_data_byte(pick_data());
                    link_bytes_q.push_back(ESC_BYTE);
                    link_bytes_q.push_back(FLAG_BYTE);
                end
                default: begin
                    repeat (len + 1) link_bytes_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    // Wait until the sender is drained and every expected result is in, then
    // let bytes that give no result clear the two pipeline registers.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (link_bytes_q.size() != 0 || s_tvalid || decoded_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge clk);
        end while (!o_cfg_ready);
        frame_capacity = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random_phase(input logic [15:0] cap, input logic with_pressure);
        int total;
        write_capacity(cap);
        queue_random_traffic(150, (cap < 16'd40) ? int'(cap) + 3 : 20);
        total = link_bytes_q.size();
        if (with_pressure) begin
            while (link_bytes_q.size() > total - 30) @(negedge clk);
            // Hold off the receiver while the sender keeps offering bytes.
            rx_hold_req = ~rx_hold_req;
            while (link_bytes_q.size() > total - 80) @(negedge clk);
            // Pause the sender until the block has delivered everything.
            tx_hold = 1'b1;
            while (s_tvalid || decoded_q.size() != 0) @(negedge clk);
            repeat (4) @(negedge clk);
            tx_hold = 1'b0;
        end
        wait_idle();
    endtask

    function automatic void queue_bytes(input logic [7:0] seq[]);
        foreach (seq[i]) link_bytes_q.push_back(seq[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        wait (rst_n);
        @(negedge clk);

        // Empty frame; extreme data values and both escape codes.
        queue_bytes('{FLAG_BYTE, 8'h00, 8'hFF, ESC_BYTE, ESC_FLAG_CODE,
                      ESC_BYTE, ESC_ESC_CODE, FLAG_BYTE});
        // Escape right before the terminator.
        queue_bytes('{ESC_BYTE, FLAG_BYTE});
        // Bad escape code, then a data byte that must be dropped.
        queue_bytes('{8'h41, ESC_BYTE, 8'h33, 8'h42, FLAG_BYTE});
        // An escape byte used as its own code is a bad code too.
        queue_bytes('{ESC_BYTE, ESC_BYTE, FLAG_BYTE});
        wait_idle();

        // Capacity 1: one byte fits, the terminator overflows.
        write_capacity(16'd1);
        queue_bytes('{8'h55, FLAG_BYTE, FLAG_BYTE, 8'h10});
        wait_idle();
        // Change capacity with a frame still open.
        write_capacity(16'd3);
        queue_bytes('{8'h11, FLAG_BYTE});
        wait_idle();
        // Zero capacity makes every byte an overflow.
        write_capacity(16'd0);
        queue_bytes('{8'h22, FLAG_BYTE});
        wait_idle();

        run_random_phase(16'd1, 1'b1);
        run_random_phase(16'd0, 1'b0);
        run_random_phase(16'd4, 1'b0);
        run_random_phase(16'd12, 1'b0);
        // Run one phase with no idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(CAPACITY_RESET, 1'b0);
        tx_idle_pct = 31;
        rx_idle_pct = 31;
        run_random_phase(16'($urandom_range(2, 40)), 1'b0);

        repeat (8) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: advance to the next byte once the transaction completes.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                deframe_byte(s_tdata);
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (link_bytes_q.size() != 0 && !tx_hold &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= link_bytes_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random idling, plus a long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack  <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------------
    // Print only the first few, keep counting all of them.
    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("ERROR result %0d: %s got 0x%0h, expected 0x%0h",
                     results_checked, field, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected result, out_byte",
                                int'(o_m_axis_tdata[7:0]), 0);
            end else begin
                want_result = decoded_q.pop_front();
                if (o_m_axis_tdata[7:0] != want_result.out_byte) begin
                    report_mismatch("out_byte", int'(o_m_axis_tdata[7:0]),
                                    int'(want_result.out_byte));
                end
                if (o_m_axis_tdata[23:8] != want_result.decoded_len) begin
                    report_mismatch("decoded_len", int'(o_m_axis_tdata[23:8]),
                                    int'(want_result.decoded_len));
                end
                if (o_m_axis_tlast != want_result.frame_end) begin
                    report_mismatch("frame_end", int'(o_m_axis_tlast),
                                    int'(want_result.frame_end));
                end
                if (o_m_axis_tuser != want_result.frame_status) begin
                    report_mismatch("frame_status", int'(o_m_axis_tuser),
                                    int'(want_result.frame_status));
                end
            end
            results_checked++;
        end
    end

    // Watchdog: end the run if no transaction completes for too long.
    always @(posedge clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> files.f
+incdir+design
design/bud_pkg.sv
design/bud_decode.sv
design/bud_out_reg.sv
design/byte_unstuffing_deframer_core.sv
design/bud_checker.sv
dv/tb.sv
